>>> hdl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg: shared types and constants for the 2D max pooling block
// Sample format, register map, store geometry and the records passed
// between the configuration unit, the window sequencer and the store.
// ----------------------------------------------------------------------------
`default_nettype none
package mp2d_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_POOL      = 8;
   localparam int STORE_ADDR_BITS = 15;   // row slot (3) + column (8) + channel (4)
   localparam int STORE_DEPTH   = 32768;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [2:0] REG_IN_WIDTH     = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_CHANNELS     = 3'd2;
   localparam logic [2:0] REG_POOL_WIDTH   = 3'd3;
   localparam logic [2:0] REG_POOL_HEIGHT  = 3'd4;
   localparam logic [2:0] REG_STRIDE_X     = 3'd5;
   localparam logic [2:0] REG_STRIDE_Y     = 3'd6;
   localparam logic [2:0] REG_SAME_PADDING = 3'd7;

   // Frame geometry, clamped and decoded, stable while samples stream.
   typedef struct packed {
      logic [7:0] w_m1;
      logic [7:0] h_m1;
      logic [3:0] nc_m1;
      logic [3:0] kx;
      logic [3:0] ky;
      logic [3:0] sx;
      logic [3:0] sy;
      logic       same;
      logic [1:0] px;
      logic [1:0] py;
      logic [1:0] q0x;
      logic [1:0] q0y;
      logic [3:0] r0x;
      logic [3:0] r0y;
   } geom_type;

   // One read-modify-write of a running maximum.
   typedef struct packed {
      logic [STORE_ADDR_BITS-1:0] addr;
      logic                       first;
      logic                       emit;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [7:0]                 o_row;
      logic [7:0]                 o_col;
      logic [3:0]                 chan;
      logic                       run_last;
      logic                       frame_done;
   } access_type;

endpackage
`default_nettype wire

>>> hdl/mp2d_if.sv
// ----------------------------------------------------------------------------
// mp2d_if: stream channels of the max pooling block
// Input samples and pooled results, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface mp2d_req_if import mp2d_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_of_batch;
   modport source (output valid, output sample, output last_of_batch, input ready);
   modport sink (input valid, input sample, input last_of_batch, output ready);
endinterface

interface mp2d_rsp_if import mp2d_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] max_value;
   logic [7:0]                    out_row;
   logic [7:0]                    out_col;
   logic [3:0]                    channel;
   logic                          last_of_run;
   logic                          frame_done;
   modport source (output valid, output max_value, output out_row, output out_col,
                   output channel, output last_of_run, output frame_done, input ready);
   modport sink (input valid, input max_value, input out_row, input out_col,
                 input channel, input last_of_run, input frame_done, output ready);
endinterface
`default_nettype wire

>>> hdl/mp2d_csr.sv
// ----------------------------------------------------------------------------
// mp2d_csr: configuration registers and geometry unit
// Holds the APB registers, clamps them, and after every write works out
// the leading padding of each axis with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none
module mp2d_csr import mp2d_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output geom_type                      geom,
   output logic                          geom_ready,
   output logic                          geom_done
);

   logic [8:0] in_width_ff, in_height_ff;
   logic [4:0] channels_ff;
   logic [3:0] pool_width_ff, pool_height_ff, stride_x_ff, stride_y_ff;
   logic       same_padding_ff;

   logic       wr_en;
   logic [7:0] w_m1, h_m1;
   logic [3:0] nc_m1, kx, ky, sx, sy;

   logic       busy_ff, fin_ff;
   logic [2:0] step_ff;
   logic [4:0] remx_ff, remx_in, remy_ff, remy_in;
   geom_type   geom_ff, geom_in;
   logic       done_ff;

   // Remainder of a value up to 3 divided by a stride, and the quotient.
   function automatic logic [5:0] small_div(input logic [1:0] p, input logic [3:0] s);
      logic [3:0] r;
      logic [1:0] q;
      r = {2'b00, p};
      q = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (r >= s) begin
            r = r - s;
            q = q + 2'd1;
         end
      end
      return {q, r};
   endfunction

   function automatic logic [4:0] rem_step(input logic [4:0] rem, input logic b,
                                           input logic [3:0] s);
      logic [4:0] t;
      t = {rem[3:0], b};
      if (t >= {1'b0, s}) t = t - {1'b0, s};
      return t;
   endfunction

   function automatic logic [1:0] lead_pad(input logic same, input logic [3:0] k,
                                           input logic [4:0] rem);
      logic [4:0] km1;
      logic [4:0] d;
      km1 = {1'b0, k} - 5'd1;
      d   = km1 - rem;
      if (same && km1 > rem) return d[2:1];
      return 2'd0;
   endfunction

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff     <= 9'd8;
         in_height_ff    <= 9'd8;
         channels_ff     <= 5'd1;
         pool_width_ff   <= 4'd2;
         pool_height_ff  <= 4'd2;
         stride_x_ff     <= 4'd2;
         stride_y_ff     <= 4'd2;
         same_padding_ff <= 1'b0;
      end else if (wr_en) begin
         case (paddr[4:2])
            REG_IN_WIDTH:     in_width_ff     <= pwdata[8:0];
            REG_IN_HEIGHT:    in_height_ff    <= pwdata[8:0];
            REG_CHANNELS:     channels_ff     <= pwdata[4:0];
            REG_POOL_WIDTH:   pool_width_ff   <= pwdata[3:0];
            REG_POOL_HEIGHT:  pool_height_ff  <= pwdata[3:0];
            REG_STRIDE_X:     stride_x_ff     <= pwdata[3:0];
            REG_STRIDE_Y:     stride_y_ff     <= pwdata[3:0];
            REG_SAME_PADDING: same_padding_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_IN_WIDTH:     prdata = {23'd0, in_width_ff};
         REG_IN_HEIGHT:    prdata = {23'd0, in_height_ff};
         REG_CHANNELS:     prdata = {27'd0, channels_ff};
         REG_POOL_WIDTH:   prdata = {28'd0, pool_width_ff};
         REG_POOL_HEIGHT:  prdata = {28'd0, pool_height_ff};
         REG_STRIDE_X:     prdata = {28'd0, stride_x_ff};
         REG_STRIDE_Y:     prdata = {28'd0, stride_y_ff};
         REG_SAME_PADDING: prdata = {31'd0, same_padding_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // Clamp registers to their legal ranges.
   always_comb begin
      w_m1  = (in_width_ff == 9'd0) ? 8'd0 :
              (in_width_ff > 9'd256) ? 8'd255 : 8'(in_width_ff - 9'd1);
      h_m1  = (in_height_ff == 9'd0) ? 8'd0 :
              (in_height_ff > 9'd256) ? 8'd255 : 8'(in_height_ff - 9'd1);
      nc_m1 = (channels_ff == 5'd0) ? 4'd0 :
              (channels_ff > 5'd16) ? 4'd15 : 4'(channels_ff - 5'd1);
      kx    = (pool_width_ff == 4'd0) ? 4'd1 :
              (pool_width_ff > 4'd8) ? 4'd8 : pool_width_ff;
      ky    = (pool_height_ff == 4'd0) ? 4'd1 :
              (pool_height_ff > 4'd8) ? 4'd8 : pool_height_ff;
      sx    = (stride_x_ff == 4'd0) ? 4'd1 : stride_x_ff;
      sy    = (stride_y_ff == 4'd0) ? 4'd1 : stride_y_ff;
   end

   // The total pad of an axis is pool - 1 - ((size - 1) mod stride), so one
   // remainder per axis is all the geometry needs; it takes eight steps.
   assign remx_in = rem_step(remx_ff, w_m1[3'd7 - step_ff], sx);
   assign remy_in = rem_step(remy_ff, h_m1[3'd7 - step_ff], sy);

   always_comb begin
      logic [5:0] dx, dy;
      geom_in       = '0;
      geom_in.w_m1  = w_m1;
      geom_in.h_m1  = h_m1;
      geom_in.nc_m1 = nc_m1;
      geom_in.kx    = kx;
      geom_in.ky    = ky;
      geom_in.sx    = sx;
      geom_in.sy    = sy;
      geom_in.same  = same_padding_ff;
      geom_in.px    = lead_pad(same_padding_ff, kx, remx_ff);
      geom_in.py    = lead_pad(same_padding_ff, ky, remy_ff);
      dx            = small_div(geom_in.px, sx);
      dy            = small_div(geom_in.py, sy);
      geom_in.q0x   = dx[5:4];
      geom_in.r0x   = dx[3:0];
      geom_in.q0y   = dy[5:4];
      geom_in.r0y   = dy[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset || wr_en) begin
         busy_ff <= 1'b1;
         fin_ff  <= 1'b0;
         step_ff <= 3'd0;
         remx_ff <= 5'd0;
         remy_ff <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff && !fin_ff) begin
            remx_ff <= remx_in;
            remy_ff <= remy_in;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) fin_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && fin_ff) geom_ff <= geom_in;
   end

   // Ready stays low through the cycle in which the sequencer restarts its
   // position counters, so no beat meets stale positions.
   assign geom       = geom_ff;
   assign geom_ready = !busy_ff && !done_ff;
   assign geom_done  = done_ff;

endmodule
`default_nettype wire

>>> hdl/mp2d_seq.sv
// ----------------------------------------------------------------------------
// mp2d_seq: position tracking and window sequencer
// Tracks the position of the next sample on each axis, finds the windows
// that contain it, and issues one store access per row and column pair.
// ----------------------------------------------------------------------------
`default_nettype none
module mp2d_seq import mp2d_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire geom_type geom,
   input  wire logic  geom_ready,
   input  wire logic  geom_done,
   mp2d_req_if.sink   req_ch,
   output access_type acc,
   output logic       acc_valid,
   input  wire logic  acc_ready
);

   typedef struct packed {
      logic [7:0] hit;
      logic [7:0] first;
      logic [7:0] last;
      logic [7:0] lastwin;
   } hits_type;

   // Axis tracker: x is the position, q and r the quotient and remainder of
   // (x + pad) by the stride.
   logic [7:0] xc_ff, xr_ff;
   logic [8:0] qc_ff, qr_ff;
   logic [3:0] rc_ff, rr_ff;
   logic [3:0] chan_ff;

   hits_type   row_hits, col_hits;
   hits_type   rh_ff, ch_ff;
   logic [8:0] qrs_ff, qcs_ff;
   logic [3:0] chs_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic [7:0] row_rem_ff, col_rem_ff;
   logic       active_ff;

   logic       accept, issue;
   logic [2:0] dr, dc;
   logic [7:0] row_rest, col_rest;
   logic [8:0] o_row, o_col;

   function automatic hits_type axis_hits(input logic [7:0] x, input logic [8:0] q,
                                          input logic [3:0] r, input logic [1:0] p,
                                          input logic [7:0] n_m1, input logic [3:0] k,
                                          input logic [3:0] s, input logic same);
      hits_type h;
      logic [7:0] off;
      logic signed [11:0] st, lim;
      logic exists, lastw;
      h = '0;
      lim = 12'(n_m1);
      for (int i = 0; i < MAX_POOL; i++) begin
         off = 8'(8'(i) * {4'd0, s}) + {4'd0, r};
         st  = 12'(x) + 12'(p) - 12'(off);
         if (same) begin
            exists = st <= lim;
            lastw  = st + 12'(s) > lim;
         end else begin
            exists = st + 12'(k) <= lim + 12'sd1;
            lastw  = st + 12'(k) + 12'(s) > lim + 12'sd1;
         end
         if (off < {4'd0, k} && 9'(i) <= q && exists) begin
            h.hit[i]     = 1'b1;
            h.first[i]   = (off == 8'd0) || (x == 8'd0);
            h.last[i]    = (off == 8'({4'd0, k} - 8'd1)) || (x == n_m1);
            h.lastwin[i] = lastw;
         end
      end
      return h;
   endfunction

   // Highest set bit: the window with the smallest index comes first.
   function automatic logic [2:0] top_bit(input logic [7:0] m);
      logic [2:0] b;
      b = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (m[i]) b = 3'(i);
      end
      return b;
   endfunction

   assign row_hits = axis_hits(xr_ff, qr_ff, rr_ff, geom.py, geom.h_m1, geom.ky,
                               geom.sy, geom.same);
   assign col_hits = axis_hits(xc_ff, qc_ff, rc_ff, geom.px, geom.w_m1, geom.kx,
                               geom.sx, geom.same);

   assign req_ch.ready = geom_ready && !active_ff;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         xc_ff <= 8'd0; xr_ff <= 8'd0; chan_ff <= 4'd0;
         qc_ff <= 9'd0; qr_ff <= 9'd0; rc_ff <= 4'd0; rr_ff <= 4'd0;
      end else if (geom_done || (accept && req_ch.last_of_batch)) begin
         xc_ff <= 8'd0; xr_ff <= 8'd0; chan_ff <= 4'd0;
         qc_ff <= {7'd0, geom.q0x}; rc_ff <= geom.r0x;
         qr_ff <= {7'd0, geom.q0y}; rr_ff <= geom.r0y;
      end else if (accept) begin
         if (chan_ff != geom.nc_m1) begin
            chan_ff <= chan_ff + 4'd1;
         end else begin
            chan_ff <= 4'd0;
            if (xc_ff != geom.w_m1) begin
               xc_ff <= xc_ff + 8'd1;
               if (rc_ff + 4'd1 == geom.sx) begin
                  rc_ff <= 4'd0;
                  qc_ff <= qc_ff + 9'd1;
               end else begin
                  rc_ff <= rc_ff + 4'd1;
               end
            end else begin
               xc_ff <= 8'd0;
               qc_ff <= {7'd0, geom.q0x};
               rc_ff <= geom.r0x;
               if (xr_ff != geom.h_m1) begin
                  xr_ff <= xr_ff + 8'd1;
                  if (rr_ff + 4'd1 == geom.sy) begin
                     rr_ff <= 4'd0;
                     qr_ff <= qr_ff + 9'd1;
                  end else begin
                     rr_ff <= rr_ff + 4'd1;
                  end
               end else begin
                  xr_ff <= 8'd0;
                  qr_ff <= {7'd0, geom.q0y};
                  rr_ff <= geom.r0y;
               end
            end
         end
      end
   end

   assign dr       = top_bit(row_rem_ff);
   assign dc       = top_bit(col_rem_ff);
   assign row_rest = row_rem_ff & ~(8'd1 << dr);
   assign col_rest = col_rem_ff & ~(8'd1 << dc);
   assign issue    = acc_valid && acc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (accept) begin
         active_ff <= (row_hits.hit != 8'd0) && (col_hits.hit != 8'd0);
      end else if (issue && col_rest == 8'd0 && row_rest == 8'd0) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rh_ff      <= row_hits;
         ch_ff      <= col_hits;
         qrs_ff     <= qr_ff;
         qcs_ff     <= qc_ff;
         chs_ff     <= chan_ff;
         smp_ff     <= req_ch.sample;
         row_rem_ff <= row_hits.hit;
         col_rem_ff <= col_hits.hit;
      end else if (issue) begin
         if (col_rest == 8'd0) begin
            row_rem_ff <= row_rest;
            col_rem_ff <= ch_ff.hit;
         end else begin
            col_rem_ff <= col_rest;
         end
      end
   end

   assign o_row = qrs_ff - {6'd0, dr};
   assign o_col = qcs_ff - {6'd0, dc};

   always_comb begin
      acc_valid      = active_ff;
      acc.addr       = {o_row[2:0], o_col[7:0], chs_ff};
      acc.first      = rh_ff.first[dr] && ch_ff.first[dc];
      acc.emit       = rh_ff.last[dr] && ch_ff.last[dc];
      acc.sample     = smp_ff;
      acc.o_row      = o_row[7:0];
      acc.o_col      = o_col[7:0];
      acc.chan       = chs_ff;
      acc.run_last   = ((col_rest & ch_ff.last) == 8'd0) && ((row_rest & rh_ff.last) == 8'd0);
      acc.frame_done = rh_ff.lastwin[dr] && ch_ff.lastwin[dc] && (chs_ff == geom.nc_m1);
   end

endmodule
`default_nettype wire

>>> hdl/mp2d_store.sv
// ----------------------------------------------------------------------------
// mp2d_store: running maximum store and result register
// Reads a running maximum, folds the sample in, writes it back when the
// access leaves its stage and hands finished windows to the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module mp2d_store import mp2d_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire access_type acc,
   input  wire logic       acc_valid,
   output logic            acc_ready,
   mp2d_rsp_if.source      rsp_ch
);

   logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

   logic signed [SAMPLE_BITS-1:0] rd_data_ff, fwd_data_ff, rd, cur;
   logic        fwd_ff;
   logic        s1_valid_ff;
   access_type  s1_ff;
   logic        out_free, s1_adv, issue, load_out;

   logic        rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] max_value_ff;
   logic [7:0]  out_row_ff, out_col_ff;
   logic [3:0]  channel_ff;
   logic        last_of_run_ff, frame_done_ff;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv    = s1_valid_ff && (!s1_ff.emit || out_free);
   assign acc_ready = !s1_valid_ff || s1_adv;
   assign issue     = acc_valid && acc_ready;
   assign load_out  = s1_adv && s1_ff.emit;

   // The write of the previous access lands on the edge where the next read
   // samples the array, so a read of the same entry takes the written value.
   assign rd  = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign cur = (s1_ff.first || s1_ff.sample > rd) ? s1_ff.sample : rd;

   always_ff @(posedge clock) begin
      if (s1_adv) mem[s1_ff.addr] <= cur;
      if (issue) rd_data_ff <= mem[acc.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            fwd_ff      <= s1_adv && (s1_ff.addr == acc.addr);
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff       <= acc;
         fwd_data_ff <= cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         max_value_ff   <= cur;
         out_row_ff     <= s1_ff.o_row;
         out_col_ff     <= s1_ff.o_col;
         channel_ff     <= s1_ff.chan;
         last_of_run_ff <= s1_ff.run_last;
         frame_done_ff  <= s1_ff.frame_done;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.max_value   = max_value_ff;
   assign rsp_ch.out_row     = out_row_ff;
   assign rsp_ch.out_col     = out_col_ff;
   assign rsp_ch.channel     = channel_ff;
   assign rsp_ch.last_of_run = last_of_run_ff;
   assign rsp_ch.frame_done  = frame_done_ff;

endmodule
`default_nettype wire

>>> hdl/max_pool_2d_forward.sv
// ----------------------------------------------------------------------------
// max_pool_2d_forward: streaming 2D max pooling, top level
// Samples arrive row, column, channel; each window maximum leaves with its
// output row, column and channel when the window's clipped extent is done.
// ----------------------------------------------------------------------------
// A sample makes one store access for each of the R * C pooling windows
// that contain it, R vertically and C horizontally, and the next sample is
// taken once all have issued; a sample in no window makes none. The running
// maxima sit in one single-port-read store that sees one read-modify-write
// per cycle while the result register does not stall it. After reset and
// after every register write the block computes its padding with ready
// low, and the position counters restart at the top left of the frame.
`default_nettype none
module max_pool_2d_forward import mp2d_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   mp2d_req_if.sink                      req_ch,
   mp2d_rsp_if.source                    rsp_ch,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   geom_type   geom;
   logic       geom_ready, geom_done;
   access_type acc;
   logic       acc_valid, acc_ready;

   mp2d_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .geom       (geom),
      .geom_ready (geom_ready),
      .geom_done  (geom_done)
   );

   mp2d_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .geom_ready (geom_ready),
      .geom_done  (geom_done),
      .req_ch     (req_ch),
      .acc        (acc),
      .acc_valid  (acc_valid),
      .acc_ready  (acc_ready)
   );

   mp2d_store u_store (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .acc_valid  (acc_valid),
      .acc_ready  (acc_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

>>> hdl/mp2d_checker.sv
// ----------------------------------------------------------------------------
// mp2d_checker: port-level checks for the max pooling block
// Watches the stream and configuration ports of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mp2d_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last_of_run,
   input wire logic rsp_frame_done,
   input wire logic pready
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // The frame's final window is always the last result of its sample.
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run)
      else $error("frame end not on last result of a run");

   // Reset empties the result register and starts the padding computation.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not idle after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready dropped");

endmodule

bind max_pool_2d_forward mp2d_checker u_mp2d_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_last_of_run (rsp_ch.last_of_run),
   .rsp_frame_done  (rsp_ch.frame_done),
   .pready          (pready)
);
`default_nettype wire

>>> sim/max_pool_2d_forward_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_pool_2d_forward_tb: self-checking bench for the 2D max pooling block
// Streams frames through the sample channel under several window, stride
// and padding settings. A behavioral model of the pooling windows predicts
// every result beat, and a monitor checks the beats in order.
// ----------------------------------------------------------------------------
module max_pool_2d_forward_tb;
   import mp2d_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int STORE_ROW    = 256 * 16;

   typedef struct {
      logic signed [15:0] max_value;
      logic [7:0]         out_row;
      logic [7:0]         out_col;
      logic [3:0]         channel;
      logic               last_of_run;
      logic               frame_done;
   } pooled_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   mp2d_req_if req_if ();
   mp2d_rsp_if rsp_if ();

   max_pool_2d_forward i_dut (
      .clock(clock), .reset(reset), .req_ch(req_if), .rsp_ch(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Model state: registers, running maxima and the next sample's position.
   logic [8:0] cfg_reg [8];
   int         window_max [8 * STORE_ROW];
   int         row_at, col_at, chan_at;
   pooled_t    pooled_q [$];

   int send_idle_pct, recv_idle_pct;
   int mismatches, samples_sent, results_seen, cycles;

   initial begin
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.last_of_batch = 1'b0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic axis_size(input int n, k, s, input bit same, output int m, output int p);
      int tot;
      if (same) begin
         m = (n - 1) / s + 1;
         tot = (m - 1) * s + k;
         p = (tot > n) ? (tot - n) / 2 : 0;
      end else begin
         m = (k <= n) ? (n - k) / s + 1 : 0;
         p = 0;
      end
   endtask

   task automatic axis_windows(input int x, n, k, s, p, m, output int cnt,
                               output int wo [8], output bit wf [8], output bit wl [8]);
      int xp, hi, lo, st, en, cs, ce;
      cnt = 0;
      for (int i = 0; i < 8; i++) begin
         wo[i] = 0; wf[i] = 0; wl[i] = 0;
      end
      if (m != 0) begin
         xp = x + p;
         hi = xp / s;
         if (hi > m - 1) hi = m - 1;
         lo = hi;
         while (lo > 0 && (lo - 1) * s + k > xp) lo--;
         for (int o = lo; o <= hi && cnt < 8; o++) begin
            st = o * s;
            en = o * s + k;
            if (st <= xp && xp < en) begin
               cs = (st > p) ? st : p;
               ce = (en < n + p) ? en : n + p;
               wo[cnt] = o;
               wf[cnt] = (xp == cs);
               wl[cnt] = (xp + 1 == ce);
               cnt++;
            end
         end
      end
   endtask

   // Folds one sample into every window that holds it and queues the maxima
   // of the windows that it completes.
   task automatic pool_sample(input logic signed [15:0] sample, input bit batch_end);
      int w, ht, nc, pw, ph, sx, sy, mw, mh, pxl, pyt, nr, ncol, idx, cur;
      bit same;
      int ro [8], co [8];
      bit rf [8], rl [8], cf [8], cl [8];
      pooled_t run [$];
      pooled_t r;
      w = clamp(cfg_reg[0], 1, 256);
      ht = clamp(cfg_reg[1], 1, 256);
      nc = clamp(cfg_reg[2], 1, 16);
      pw = clamp(cfg_reg[3], 1, 8);
      ph = clamp(cfg_reg[4], 1, 8);
      sx = (cfg_reg[5] != 0) ? cfg_reg[5] : 1;
      sy = (cfg_reg[6] != 0) ? cfg_reg[6] : 1;
      same = cfg_reg[7][0];
      if (row_at >= ht || col_at >= w || chan_at >= nc) begin
         row_at = 0; col_at = 0; chan_at = 0;
      end
      axis_size(w, pw, sx, same, mw, pxl);
      axis_size(ht, ph, sy, same, mh, pyt);
      axis_windows(row_at, ht, ph, sy, pyt, mh, nr, ro, rf, rl);
      axis_windows(col_at, w, pw, sx, pxl, mw, ncol, co, cf, cl);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < ncol; j++) begin
            idx = ((ro[i] % 8) * 256 + co[j]) * 16 + chan_at;
            if (rf[i] && cf[j])
               cur = sample;
            else
               cur = (sample > window_max[idx]) ? sample : window_max[idx];
            window_max[idx] = cur;
            if (rl[i] && cl[j] && run.size() < 64) begin
               r.max_value = cur[15:0];
               r.out_row = ro[i][7:0];
               r.out_col = co[j][7:0];
               r.channel = chan_at[3:0];
               r.last_of_run = 1'b0;
               r.frame_done = (ro[i] == mh - 1 && co[j] == mw - 1 && chan_at == nc - 1);
               run.push_back(r);
            end
         end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pooled_q.push_back(run[i]);
      chan_at++;
      if (chan_at >= nc) begin
         chan_at = 0;
         col_at++;
         if (col_at >= w) begin
            col_at = 0;
            row_at++;
            if (row_at >= ht) row_at = 0;
         end
      end
      if (batch_end) begin
         row_at = 0; col_at = 0; chan_at = 0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pooled_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: value %0d row %0d col %0d ch %0d",
                        rsp_if.max_value, rsp_if.out_row, rsp_if.out_col, rsp_if.channel);
         end else begin
            pooled_t e;
            e = pooled_q.pop_front();
            if (rsp_if.max_value !== e.max_value || rsp_if.out_row !== e.out_row ||
                rsp_if.out_col !== e.out_col || rsp_if.channel !== e.channel ||
                rsp_if.last_of_run !== e.last_of_run ||
                rsp_if.frame_done !== e.frame_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Result mismatch: expected %0d r%0d c%0d ch%0d l%0b f%0b, ",
                            "got %0d r%0d c%0d ch%0d l%0b f%0b"},
                           e.max_value, e.out_row, e.out_col, e.channel, e.last_of_run,
                           e.frame_done, rsp_if.max_value, rsp_if.out_row, rsp_if.out_col,
                           rsp_if.channel, rsp_if.last_of_run, rsp_if.frame_done);
            end
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] sample, input bit batch_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= sample;
      req_if.last_of_batch <= batch_end;
      pool_sample(sample, batch_end);
      samples_sent++;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic wait_results;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pooled_q.size() != 0) @(posedge clock);
   endtask

   // A sample may still be in flight without any result, so idle a while.
   task automatic quiesce;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [8:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(index) << 2;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_IN_WIDTH, REG_IN_HEIGHT: cfg_reg[index] = value;
         REG_CHANNELS:                cfg_reg[index] = value & 9'h1f;
         REG_SAME_PADDING:            cfg_reg[index] = value & 9'h001;
         default:                     cfg_reg[index] = value & 9'h00f;
      endcase
      row_at = 0; col_at = 0; chan_at = 0;
   endtask

   task automatic set_geometry(input int w, ht, nc, pw, ph, sx, sy, same);
      quiesce();
      write_reg(REG_IN_WIDTH, 9'(w));
      write_reg(REG_IN_HEIGHT, 9'(ht));
      write_reg(REG_CHANNELS, 9'(nc));
      write_reg(REG_POOL_WIDTH, 9'(pw));
      write_reg(REG_POOL_HEIGHT, 9'(ph));
      write_reg(REG_STRIDE_X, 9'(sx));
      write_reg(REG_STRIDE_Y, 9'(sy));
      write_reg(REG_SAME_PADDING, 9'(same));
   endtask

   function automatic logic signed [15:0] any_sample();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int frame_len();
      return clamp(cfg_reg[0], 1, 256) * clamp(cfg_reg[1], 1, 256) * clamp(cfg_reg[2], 1, 16);
   endfunction

   task automatic test_reset_geometry;
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      for (int i = 2; i < 16; i++) send_sample(any_sample(), 1'b0);
   endtask

   task automatic test_same_padding;
      set_geometry(5, 3, 2, 3, 2, 2, 2, 1);
      for (int i = 0; i < 30; i++) send_sample(any_sample(), 1'b0);
      // Stride wider than the window leaves gaps and no padding.
      set_geometry(4, 4, 1, 1, 1, 3, 3, 1);
      for (int i = 0; i < 16; i++) send_sample(any_sample(), 1'b0);
   endtask

   task automatic test_oversize_window;
      // Valid padding with a window wider than the frame yields nothing.
      set_geometry(3, 3, 1, 8, 2, 1, 1, 0);
      for (int i = 0; i < 9; i++) send_sample(any_sample(), 1'b0);
   endtask

   task automatic test_batch_mark;
      set_geometry(4, 4, 2, 2, 2, 1, 1, 0);
      for (int i = 0; i < 10; i++) send_sample(any_sample(), i == 9);
      for (int i = 0; i < 16; i++) send_sample(any_sample(), 1'b0);
   endtask

   task automatic test_wide_extremes;
      set_geometry(256, 1, 1, 1, 1, 1, 1, 0);
      for (int i = 0; i < 256; i++) send_sample(any_sample(), 1'b0);
      set_geometry(2, 2, 16, 8, 8, 8, 8, 1);
      for (int i = 0; i < 64; i++) send_sample(any_sample(), 1'b0);
      // Out of range codes are clamped by the block.
      set_geometry(0, 511, 31, 15, 0, 0, 15, 1);
      for (int i = 0; i < 20; i++) send_sample(any_sample(), 1'b0);
   endtask

   task automatic test_random_frames(input int budget);
      int sent, len;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9) == 0)
            set_geometry($urandom_range(511), $urandom_range(12), $urandom_range(31),
                         $urandom_range(15), $urandom_range(15), $urandom_range(15),
                         $urandom_range(15), $urandom_range(1));
         else
            set_geometry($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(1, 3),
                         $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                         $urandom_range(1, 8), $urandom_range(1));
         len = frame_len();
         if (len > 200) len = 200;
         for (int f = 0; f < 2 && sent < budget; f++) begin
            for (int i = 0; i < len && sent < budget; i++) begin
               send_sample(any_sample(), $urandom_range(39) == 0);
               sent++;
            end
            if ($urandom_range(3) == 0) wait_results();
         end
      end
   endtask

   initial begin
      mismatches = 0;
      samples_sent = 0;
      results_seen = 0;
      cycles = 0;
      send_idle_pct = 33;
      recv_idle_pct = 88;
      cfg_reg = '{9'd8, 9'd8, 9'd1, 9'd2, 9'd2, 9'd2, 9'd2, 9'd0};
      foreach (window_max[i]) window_max[i] = 0;
      row_at = 0; col_at = 0; chan_at = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_same_padding();
      test_oversize_window();
      test_batch_mark();
      test_random_frames(12);
      send_idle_pct = 88;
      recv_idle_pct = 33;
      test_wide_extremes();
      test_random_frames(12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(12);

      quiesce();
      $display("Streamed %0d samples and checked %0d pooled results", samples_sent,
               results_seen);
      $display("Covered valid and same padding, clamped codes, batch marks and stalls");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
hdl/mp2d_pkg.sv
hdl/mp2d_if.sv
hdl/mp2d_csr.sv
hdl/mp2d_seq.sv
hdl/mp2d_store.sv
hdl/max_pool_2d_forward.sv
hdl/mp2d_checker.sv
sim/max_pool_2d_forward_tb.sv
